// File: hdl/smap_pkg.sv
package smap_pkg;

  localparam int unsigned SAVE_RAM_BYTES = 8192;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAP_W    = 18;
  localparam int unsigned BANKS_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BANKS_W-1:0] PRG_BANKS_RST = 5'd2;
  localparam logic [BANKS_W-1:0] CHR_BANKS_RST = 5'd0;
  localparam logic [4:0]         CONTROL_RST   = 5'h1c;
  localparam logic [4:0]         PRG_MODE_BITS = 5'h0c;
  localparam logic [2:0]         LAST_SHIFT    = 3'd4;

  typedef enum logic [2:0] {
    OP_CPU_RD = 3'd0,
    OP_CPU_WR = 3'd1,
    OP_PPU_RD = 3'd2,
    OP_PPU_WR = 3'd3,
    OP_RESET  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    RGN_SRAM = 2'd0,
    RGN_PRG  = 2'd1,
    RGN_CHR  = 2'd2,
    RGN_NONE = 2'd3
  } region_e;

  typedef enum logic [1:0] {
    TGT_CONTROL = 2'd0,
    TGT_CHR_LOW = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PRG     = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    PRG_WHOLE_A = 2'd0,
    PRG_WHOLE_B = 2'd1,
    PRG_FIX_LOW = 2'd2,
    PRG_FIX_HIGH = 2'd3
  } prg_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRG_BANKS = 2'd0,
    CFG_CHR_BANKS = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [BANKS_W-1:0] prg_banks;
    logic [BANKS_W-1:0] chr_banks;
  } cfg_t;

  typedef struct packed {
    logic [4:0] shift_value;
    logic [2:0] shift_count;
    logic [4:0] control;
    logic [4:0] chr_low_bank;
    logic [4:0] chr_high_bank;
    logic [3:0] chr_whole_bank;
    logic [2:0] prg_whole_bank;
    logic [3:0] prg_low_bank;
    logic [3:0] prg_high_bank;
    logic [1:0] mirror_state;
  } state_t;

  typedef struct packed {
    region_e           region;
    logic [MAP_W-1:0]  mapped_address;
    logic              write_strobe;
    logic [DATA_W-1:0] out_data;
    logic              accepted;
  } result_t;

  function automatic logic [3:0] last_prg_bank(logic [BANKS_W-1:0] prg_banks);
    return prg_banks[3:0] - 4'd1;
  endfunction

  function automatic state_t reset_state(logic [BANKS_W-1:0] prg_banks);
    state_t s;
    s                = '0;
    s.control        = CONTROL_RST;
    s.prg_high_bank  = last_prg_bank(prg_banks);
    s.mirror_state   = 2'd3;
    return s;
  endfunction

endpackage

// File: hdl/smap_regs.sv
module smap_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [smap_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [smap_pkg::BANKS_W-1:0]      cfg_data_i,
  input  logic                              step_i,
  input  smap_pkg::op_e                     op_i,
  input  logic [smap_pkg::ADDR_W-1:0]       addr_i,
  input  logic [smap_pkg::DATA_W-1:0]       data_i,
  output smap_pkg::cfg_t                    cfg_o,
  output smap_pkg::state_t                  st_o,
  output smap_pkg::state_t                  st_next_o
);

  smap_pkg::cfg_t   cfg_q;
  smap_pkg::state_t st_q, st_d;
  logic [4:0]       value;
  smap_pkg::target_e target;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_banks <= smap_pkg::PRG_BANKS_RST;
      cfg_q.chr_banks <= smap_pkg::CHR_BANKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        smap_pkg::CFG_PRG_BANKS: cfg_q.prg_banks <= cfg_data_i;
        smap_pkg::CFG_CHR_BANKS: cfg_q.chr_banks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign value  = {data_i[0], st_q.shift_value[4:1]};
  assign target = smap_pkg::target_e'(addr_i[14:13]);

  always_comb begin
    st_d = st_q;
    if (step_i) begin
      unique case (op_i)
        smap_pkg::OP_CPU_WR: begin
          if (addr_i[15]) begin
            if (data_i[7]) begin
              st_d.shift_value = '0;
              st_d.shift_count = '0;
              st_d.control     = st_q.control | smap_pkg::PRG_MODE_BITS;
            end else if (st_q.shift_count >= smap_pkg::LAST_SHIFT) begin
              st_d.shift_value = '0;
              st_d.shift_count = '0;
              unique case (target)
                smap_pkg::TGT_CONTROL: begin
                  st_d.control      = value;
                  st_d.mirror_state = value[1:0];
                end
                smap_pkg::TGT_CHR_LOW: begin
                  if (st_q.control[4]) begin
                    st_d.chr_low_bank = value;
                  end else begin
                    st_d.chr_whole_bank = value[4:1];
                  end
                end
                smap_pkg::TGT_CHR_HIGH: begin
                  if (st_q.control[4]) begin
                    st_d.chr_high_bank = value;
                  end
                end
                smap_pkg::TGT_PRG: begin
                  unique case (smap_pkg::prg_mode_e'(st_q.control[3:2]))
                    smap_pkg::PRG_WHOLE_A,
                    smap_pkg::PRG_WHOLE_B: st_d.prg_whole_bank = value[3:1];
                    smap_pkg::PRG_FIX_LOW: begin
                      st_d.prg_low_bank  = '0;
                      st_d.prg_high_bank = value[3:0];
                    end
                    smap_pkg::PRG_FIX_HIGH: begin
                      st_d.prg_low_bank  = value[3:0];
                      st_d.prg_high_bank = smap_pkg::last_prg_bank(cfg_q.prg_banks);
                    end
                    default: ;
                  endcase
                end
                default: ;
              endcase
            end else begin
              st_d.shift_value = value;
              st_d.shift_count = st_q.shift_count + 3'd1;
            end
          end
        end
        smap_pkg::OP_RESET: st_d = smap_pkg::reset_state(cfg_q.prg_banks);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= smap_pkg::reset_state(smap_pkg::PRG_BANKS_RST);
    end else begin
      st_q <= st_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign st_o      = st_q;
  assign st_next_o = st_d;

endmodule

// File: hdl/smap_xlat.sv
module smap_xlat #(
  parameter int unsigned SaveRamBytes = smap_pkg::SAVE_RAM_BYTES
) (
  input  smap_pkg::op_e                 op_i,
  input  logic [smap_pkg::ADDR_W-1:0]   addr_i,
  input  logic [smap_pkg::DATA_W-1:0]   data_i,
  input  smap_pkg::cfg_t                cfg_i,
  input  smap_pkg::state_t              st_i,
  output smap_pkg::result_t             res_o
);

  // The save RAM size is a power of two, so the wrap is a mask.
  localparam int unsigned SaveAw = $clog2(SaveRamBytes);

  logic [smap_pkg::MAP_W-1:0] sram_addr, prg_addr, chr_addr, chr_ram_addr;
  logic [3:0]                 prg_bank;
  logic [4:0]                 chr_bank;
  logic                       chr_ram;

  assign chr_ram      = (cfg_i.chr_banks == '0);
  assign sram_addr    = smap_pkg::MAP_W'(addr_i[SaveAw-1:0]);
  assign chr_ram_addr = smap_pkg::MAP_W'(addr_i[12:0]);

  always_comb begin
    prg_bank = (addr_i[15] && addr_i[14]) ? st_i.prg_high_bank : st_i.prg_low_bank;
    if (st_i.control[3]) begin
      prg_addr = {prg_bank, addr_i[13:0]};
    end else begin
      prg_addr = {st_i.prg_whole_bank, addr_i[14:0]};
    end
  end

  always_comb begin
    chr_bank = addr_i[12] ? st_i.chr_high_bank : st_i.chr_low_bank;
    if (chr_ram) begin
      chr_addr = chr_ram_addr;
    end else if (st_i.control[4]) begin
      chr_addr = smap_pkg::MAP_W'({chr_bank, addr_i[11:0]});
    end else begin
      chr_addr = smap_pkg::MAP_W'({st_i.chr_whole_bank, addr_i[12:0]});
    end
  end

  always_comb begin
    res_o.region         = smap_pkg::RGN_NONE;
    res_o.mapped_address = '0;
    res_o.write_strobe   = 1'b0;
    res_o.out_data       = '0;
    res_o.accepted       = 1'b1;
    unique case (op_i)
      smap_pkg::OP_CPU_RD: begin
        if (!addr_i[15]) begin
          res_o.region         = smap_pkg::RGN_SRAM;
          res_o.mapped_address = sram_addr;
        end else begin
          res_o.region         = smap_pkg::RGN_PRG;
          res_o.mapped_address = prg_addr;
        end
      end
      smap_pkg::OP_CPU_WR: begin
        res_o.out_data = data_i;
        if (!addr_i[15]) begin
          res_o.region         = smap_pkg::RGN_SRAM;
          res_o.mapped_address = sram_addr;
          res_o.write_strobe   = 1'b1;
        end
      end
      smap_pkg::OP_PPU_RD: begin
        res_o.region         = smap_pkg::RGN_CHR;
        res_o.mapped_address = chr_addr;
      end
      smap_pkg::OP_PPU_WR: begin
        res_o.out_data = data_i;
        if (chr_ram) begin
          res_o.region         = smap_pkg::RGN_CHR;
          res_o.mapped_address = chr_ram_addr;
          res_o.write_strobe   = 1'b1;
        end else begin
          res_o.accepted = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/serial_bank_mapper.sv
// Bank-switching cartridge mapper with a serial register load port.
// Each input beat carries one CPU read or write, one PPU read or write, or a
// mapper reset command, and gives exactly one result beat with the memory
// region, the byte address within it, a write strobe, the write byte, an
// accept flag and the nametable mirroring after the access.
// The input beat is captured in an input register; while it is held there
// the translation and the serial register update are done, and the result
// is loaded into the output register when that register is free or being
// drained. One beat is taken every cycle while the receiver accepts results.
// When the receiver stalls, the result stays in the output register, the
// captured input beat waits in the input register, and input ready drops
// once both are occupied.
// The configuration channel writes the bank counts and is always ready;
// the user must write it only while no beat is in flight (not enforced).
// Reset clears both pipeline stages, loads the bank counts with two program
// banks and character RAM, and puts the mapper in its power-on state.
module serial_bank_mapper #(
  parameter int unsigned SaveRamBytes = smap_pkg::SAVE_RAM_BYTES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [smap_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [smap_pkg::BANKS_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        opcode_i,
  input  logic [smap_pkg::ADDR_W-1:0]       address_i,
  input  logic [smap_pkg::DATA_W-1:0]       write_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        region_o,
  output logic [smap_pkg::MAP_W-1:0]        mapped_address_o,
  output logic                              write_strobe_o,
  output logic [smap_pkg::DATA_W-1:0]       out_data_o,
  output logic                              accepted_o,
  output logic [1:0]                        mirroring_o
);

  logic                          in_valid_q;
  smap_pkg::op_e                 op_q;
  logic [smap_pkg::ADDR_W-1:0]   addr_q;
  logic [smap_pkg::DATA_W-1:0]   data_q;
  logic                          out_valid_q;
  smap_pkg::result_t             res_q, res_d;
  logic [1:0]                    mirror_q;
  logic                          advance, step;
  smap_pkg::cfg_t                cfg;
  smap_pkg::state_t              st, st_next;

  assign advance     = !out_valid_q || out_ready_i;
  assign step        = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= smap_pkg::op_e'(opcode_i);
      addr_q <= address_i;
      data_q <= write_data_i;
    end
  end

  smap_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .op_i        (op_q),
    .addr_i      (addr_q),
    .data_i      (data_q),
    .cfg_o       (cfg),
    .st_o        (st),
    .st_next_o   (st_next)
  );

  smap_xlat #(
    .SaveRamBytes (SaveRamBytes)
  ) u_xlat (
    .op_i   (op_q),
    .addr_i (addr_q),
    .data_i (data_q),
    .cfg_i  (cfg),
    .st_i   (st),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q    <= res_d;
      mirror_q <= st_next.mirror_state;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign region_o         = res_q.region;
  assign mapped_address_o = res_q.mapped_address;
  assign write_strobe_o   = res_q.write_strobe;
  assign out_data_o       = res_q.out_data;
  assign accepted_o       = res_q.accepted;
  assign mirroring_o      = mirror_q;

endmodule
